// ===== sv/rational_arithmetic_unit_core_macros.svh =====
// Assertion helpers for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rau_pkg.sv =====
package rau_pkg;

  localparam int unsigned DefaultWidth = 32;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_NEG = 3'd4;
  localparam logic [2:0] CMD_INC = 3'd5;
  localparam logic [2:0] CMD_DEC = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_GCD_INIT,
    S_GCD,
    S_DIVN_INIT,
    S_DIVN,
    S_DIVD_INIT,
    S_DIVD,
    S_DONE
  } rau_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic gcd_init;
    logic gcd_step;
    logic divn_init;
    logic divd_init;
    logic div_step;
    logic divd_store_n;
    logic finish;
  } rau_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early_err;
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } rau_stat_t;

endpackage

// ===== sv/rau_datapath.sv =====
module rau_datapath import rau_pkg::*; #(
  parameter int unsigned WIDTH = DefaultWidth
) (
  input  logic                    clk_i,
  input  rau_cmd_t                cmd_i,
  output rau_stat_t               stat_o,
  input  logic [2:0]              command_i,
  input  logic signed [WIDTH-1:0] a_num_i,
  input  logic signed [WIDTH-1:0] a_den_i,
  input  logic signed [WIDTH-1:0] b_num_i,
  input  logic signed [WIDTH-1:0] b_den_i,
  output logic signed [WIDTH-1:0] res_num_o,
  output logic [WIDTH-2:0]        res_den_o,
  output logic [1:0]              status_o
);

  localparam int unsigned WW = 2 * WIDTH + 1;
  localparam int unsigned CW = $clog2(WW + 1);

  logic [2:0]       cmd_q;
  logic             an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic [WW-1:0]    p1_q, p2_q, p3_q;
  logic             p1_s_q, p2_s_q, p3_s_q;
  logic [WW-1:0]    n_q, d_q;
  logic             n_s_q, d_s_q;
  logic [WW-1:0]    x_q, y_q, g_q;
  logic [WW-1:0]    quo_q, rem_q, dvd_q;
  logic [CW-1:0]    cnt_q;
  logic [WW-1:0]    nm_q;
  logic [1:0]       early_q;
  logic signed [WIDTH-1:0] res_num_q;
  logic [WIDTH-2:0] res_den_q;
  logic [1:0]       status_q;

  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic [WW-1:0]    m1, m2, m3;
  logic [WW-1:0]    s_mag;
  logic             s_neg;
  logic             t_neg;
  logic [WW-1:0]    t_mag;
  logic [WW:0]      rem_sh;
  logic [WW:0]      rem_sub;
  logic [WW-1:0]    half_w, dlim;
  logic             fneg;

  function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
    mag = v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  assign an_m = mag(a_num_i);
  assign ad_m = mag(a_den_i);
  assign bn_m = mag(b_num_i);
  assign bd_m = mag(b_den_i);

  // sign-magnitude add of two registered terms
  always_comb begin
    t_neg = p2_s_q;
    t_mag = p2_q;
    if (cmd_q == CMD_SUB || cmd_q == CMD_DEC) t_neg = ~p2_s_q;
    if (p1_s_q == t_neg) begin
      s_neg = p1_s_q;
      s_mag = p1_q + t_mag;
    end else if (p1_q >= t_mag) begin
      s_neg = p1_s_q;
      s_mag = p1_q - t_mag;
    end else begin
      s_neg = t_neg;
      s_mag = t_mag - p1_q;
    end
  end

  // one multiplier per product, WIDTHxWIDTH each, registered
  always_comb begin
    m1 = '0; m2 = '0; m3 = '0;
    case (cmd_q)
      CMD_ADD, CMD_SUB: begin
        m1 = WW'(an_q * bd_q);
        m2 = WW'(bn_q * ad_q);
        m3 = WW'(ad_q * bd_q);
      end
      CMD_MUL: begin
        m1 = WW'(an_q * bn_q);
        m3 = WW'(ad_q * bd_q);
      end
      CMD_DIV: begin
        m1 = WW'(an_q * bd_q);
        m3 = WW'(ad_q * bn_q);
      end
      CMD_INC, CMD_DEC: begin
        m1 = WW'(an_q);
        m2 = WW'(ad_q);
        m3 = WW'(ad_q);
      end
      default: begin
        m1 = WW'(an_q);
        m3 = WW'(ad_q);
      end
    endcase
  end

  assign rem_sh  = {rem_q, dvd_q[WW-1]};
  assign rem_sub = rem_sh - {1'b0, g_q};
  assign half_w  = WW'(1) << (WIDTH - 1);
  assign dlim    = half_w - 1'b1;
  assign fneg    = n_s_q ^ d_s_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      an_q   <= an_m; ad_q <= ad_m; bn_q <= bn_m; bd_q <= bd_m;
      an_s_q <= a_num_i[WIDTH-1]; ad_s_q <= a_den_i[WIDTH-1];
      bn_s_q <= b_num_i[WIDTH-1]; bd_s_q <= b_den_i[WIDTH-1];
      if (ad_m == '0 || (command_i[2] == 1'b0 && bd_m == '0)) early_q <= ST_ZERO_DEN;
      else if (command_i == CMD_DIV && bn_m == '0)             early_q <= ST_DIV_ZERO;
      else                                                    early_q <= ST_OK;
    end
    if (cmd_i.mul) begin
      p1_q <= m1; p2_q <= m2; p3_q <= m3;
      case (cmd_q)
        CMD_ADD, CMD_SUB: begin
          p1_s_q <= an_s_q ^ bd_s_q; p2_s_q <= bn_s_q ^ ad_s_q; p3_s_q <= ad_s_q ^ bd_s_q;
        end
        CMD_MUL: begin
          p1_s_q <= an_s_q ^ bn_s_q; p2_s_q <= 1'b0; p3_s_q <= ad_s_q ^ bd_s_q;
        end
        CMD_DIV: begin
          p1_s_q <= an_s_q ^ bd_s_q; p2_s_q <= 1'b0; p3_s_q <= ad_s_q ^ bn_s_q;
        end
        CMD_NEG: begin
          p1_s_q <= ~an_s_q; p2_s_q <= 1'b0; p3_s_q <= ad_s_q;
        end
        CMD_INC, CMD_DEC: begin
          p1_s_q <= an_s_q; p2_s_q <= ad_s_q; p3_s_q <= ad_s_q;
        end
        default: begin
          p1_s_q <= an_s_q; p2_s_q <= 1'b0; p3_s_q <= ad_s_q;
        end
      endcase
    end
    if (cmd_i.sum) begin
      n_q   <= s_mag;
      n_s_q <= s_neg;
      d_q   <= p3_q;
      d_s_q <= p3_s_q;
    end
    // GCD setup: x and y take the numerator and denominator magnitudes
    if (cmd_i.gcd_init) begin
      x_q <= n_q;
      y_q <= d_q;
    end
    if (cmd_i.gcd_step) begin
      // binary GCD on x,y (both nonzero); cnt holds the shared power of two count
      if (x_q == y_q) begin
        y_q <= '0;
      end else if (x_q[0] == 1'b0 && y_q[0] == 1'b0) begin
        x_q <= x_q >> 1; y_q <= y_q >> 1; cnt_q <= cnt_q + 1'b1;
      end else if (x_q[0] == 1'b0) begin
        x_q <= x_q >> 1;
      end else if (y_q[0] == 1'b0) begin
        y_q <= y_q >> 1;
      end else if (x_q > y_q) begin
        x_q <= (x_q - y_q) >> 1;
      end else begin
        y_q <= (y_q - x_q) >> 1;
      end
    end
    if (cmd_i.gcd_init) cnt_q <= '0;
    if (cmd_i.divn_init || cmd_i.divd_init) begin
      if (cmd_i.divn_init) g_q <= x_q << cnt_q;
      dvd_q <= cmd_i.divn_init ? n_q : d_q;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= CW'(WW);
    end
    if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q - 1'b1;
      if (!rem_sub[WW]) begin
        rem_q <= rem_sub[WW-1:0];
        quo_q <= {quo_q[WW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[WW-1:0];
        quo_q <= {quo_q[WW-2:0], 1'b0};
      end
    end
    if (cmd_i.divd_store_n) nm_q <= quo_q;
    if (cmd_i.finish) begin
      res_num_q <= '0;
      res_den_q <= '0;
      if (early_q != ST_OK) begin
        status_q <= early_q;
      end else if (n_q == '0) begin
        status_q  <= ST_OK;
        res_den_q <= (WIDTH-1)'(1);
      end else if (quo_q > dlim || nm_q > (fneg ? half_w : dlim)) begin
        status_q <= ST_OVERFLOW;
      end else begin
        status_q  <= ST_OK;
        res_num_q <= fneg ? WIDTH'(~nm_q + 1'b1) : nm_q[WIDTH-1:0];
        res_den_q <= quo_q[WIDTH-2:0];
      end
    end
  end

  assign stat_o.early_err = (early_q != ST_OK);
  assign stat_o.num_zero  = (n_q == '0);
  assign stat_o.gcd_done  = (y_q == '0) || (x_q == '0);
  assign stat_o.div_done  = (cnt_q == '0);

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign status_o  = status_q;

endmodule

// ===== sv/rau_ctrl.sv =====
module rau_ctrl import rau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  rau_stat_t stat_i,
  output rau_cmd_t  cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  `include "rational_arithmetic_unit_core_macros.svh"

  rau_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != S_IDLE);
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_GCD_INIT;
      end
      S_GCD_INIT: begin
        if (stat_i.early_err || stat_i.num_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          state_d = S_DIVN_INIT;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIVN_INIT: begin
        cmd_o.divn_init = 1'b1;
        state_d         = S_DIVN;
      end
      S_DIVN: begin
        if (stat_i.div_done) begin
          cmd_o.divd_store_n = 1'b1;
          state_d            = S_DIVD_INIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DIVD_INIT: begin
        cmd_o.divd_init = 1'b1;
        state_d         = S_DIVD;
      end
      S_DIVD: begin
        if (stat_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  `RAU_ASSERT_NEXT(a_start_leaves_idle, clk_i, rst_ni, state_q == S_IDLE && start_i, state_q == S_MUL, "start ignored")
  `RAU_ASSERT_NEXT(a_done_one_cycle, clk_i, rst_ni, done_o, !done_o && state_q == S_IDLE, "done held")
  `RAU_ASSERT_IMPL(a_one_divide_cmd, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.divn_init, cmd_o.divd_init, cmd_o.div_step}), "divider commands overlap")

endmodule

// ===== sv/rational_arithmetic_unit_core.sv =====
// Sequence per transfer: load, multiply, sum; an error or zero result then finishes,
// otherwise binary GCD steps and two restoring divides (numerator, denominator) follow.
// One transfer in flight; busy is high from the accept edge through the
// done_o cycle, so the next accept waits until the controller is back in idle.
// The result is shown for one cycle with done_o; the receiver cannot stall it.
// Reset (rst_ni low, asynchronous) returns the controller to idle.
module rational_arithmetic_unit_core import rau_pkg::*; #(
  parameter int unsigned WIDTH = DefaultWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  output logic                    done_o,
  input  logic [2:0]              command_i,
  input  logic signed [WIDTH-1:0] a_num_i,
  input  logic signed [WIDTH-1:0] a_den_i,
  input  logic signed [WIDTH-1:0] b_num_i,
  input  logic signed [WIDTH-1:0] b_den_i,
  output logic signed [WIDTH-1:0] res_num_o,
  output logic [WIDTH-2:0]        res_den_o,
  output logic [1:0]              status_o
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  // Controller walks multiply, sum, GCD and the two exact divisions.
  rau_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  // Datapath holds operands, products, GCD registers and the shared divider.
  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .command_i(command_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .res_num_o(res_num_o),
    .res_den_o(res_den_o),
    .status_o (status_o)
  );

endmodule

// ===== tb/sv/tb_rational_arithmetic_unit_core.sv =====
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit_core;
  import rau_pkg::*;

  localparam int unsigned W = 32;
  localparam logic [2:0] CMD_PASS = 3'd7;  // unused code: reduced pass-through
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                done_o;
  logic [2:0]          command_i = CMD_ADD;
  logic signed [W-1:0] a_num_i = '0;
  logic signed [W-1:0] a_den_i = '0;
  logic signed [W-1:0] b_num_i = '0;
  logic signed [W-1:0] b_den_i = '0;
  logic signed [W-1:0] res_num_o;
  logic [W-2:0]        res_den_o;
  logic [1:0]          status_o;

  rational_arithmetic_unit_core #(.WIDTH(W)) uut (
    .clk_i, .rst_ni, .start, .busy, .done_o, .command_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .res_num_o, .res_den_o, .status_o
  );

  always #2 clk_i = ~clk_i;

  // Expected fraction and status for each transfer still in flight.
  typedef struct {
    logic signed [W-1:0] num;
    logic [W-2:0]        den;
    logic [1:0]          st;
  } frac_res_t;

  frac_res_t expected_q[$];
  int   error_count = 0;
  int   sent_count = 0;
  int   checked_count = 0;
  int   status_seen[4] = '{0, 0, 0, 0};
  longint cycle_count = 0;

  // Sign-magnitude value wide enough for cross products and their sums.
  typedef struct {
    bit          neg;
    bit [127:0]  mag;
  } sm_t;

  function automatic sm_t to_sm(logic [W-1:0] v);
    sm_t r;
    logic [W-1:0] m;
    m = ~v + 1'b1;
    r.neg = v[W-1];
    r.mag = r.neg ? 128'(m) : 128'(v);
    if (r.neg && v == {1'b1, {(W-1){1'b0}}}) r.mag = 128'(1) << (W-1);
    return r;
  endfunction

  function automatic sm_t sm_mul(sm_t x, sm_t y);
    sm_t r;
    r.neg = x.neg ^ y.neg;
    r.mag = x.mag * y.mag;
    return r;
  endfunction

  function automatic sm_t sm_add(sm_t x, sm_t y);
    sm_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg; r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg; r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg; r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

  function automatic sm_t sm_flip(sm_t x);
    x.neg = ~x.neg;
    return x;
  endfunction

  // Reduced fraction result for one command, with its status.
  function automatic frac_res_t reduce_fraction(logic [2:0] cmd, logic [W-1:0] an_v,
                                                logic [W-1:0] ad_v, logic [W-1:0] bn_v,
                                                logic [W-1:0] bd_v);
    frac_res_t r;
    sm_t an, ad, bn, bd, n, d;
    bit [127:0] x, y, t, nm, dm, nlim;
    bit neg, binary;
    an = to_sm(an_v); ad = to_sm(ad_v); bn = to_sm(bn_v); bd = to_sm(bd_v);
    binary = cmd < CMD_NEG;
    r.num = '0; r.den = '0; r.st = ST_OK;
    if (ad.mag == 0 || (binary && bd.mag == 0)) begin
      r.st = ST_ZERO_DEN;
      return r;
    end
    if (cmd == CMD_DIV && bn.mag == 0) begin
      r.st = ST_DIV_ZERO;
      return r;
    end
    case (cmd)
      CMD_ADD: begin n = sm_add(sm_mul(an, bd), sm_mul(bn, ad)); d = sm_mul(ad, bd); end
      CMD_SUB: begin
        n = sm_add(sm_mul(an, bd), sm_flip(sm_mul(bn, ad))); d = sm_mul(ad, bd);
      end
      CMD_MUL: begin n = sm_mul(an, bn); d = sm_mul(ad, bd); end
      CMD_DIV: begin n = sm_mul(an, bd); d = sm_mul(ad, bn); end
      CMD_NEG: begin n = sm_flip(an); d = ad; end
      CMD_INC: begin n = sm_add(an, ad); d = ad; end
      CMD_DEC: begin n = sm_add(an, sm_flip(ad)); d = ad; end
      default: begin n = an; d = ad; end
    endcase
    if (n.mag == 0) begin
      r.den = (W-1)'(1);
      return r;
    end
    x = n.mag; y = d.mag;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    nm = n.mag / x;
    dm = d.mag / x;
    neg = n.neg ^ d.neg;
    nlim = neg ? (128'(1) << (W-1)) : ((128'(1) << (W-1)) - 1);
    if (dm > ((128'(1) << (W-1)) - 1) || nm > nlim) begin
      r.st = ST_OVERFLOW;
    end else begin
      r.num = neg ? W'(-nm) : W'(nm);
      r.den = (W-1)'(dm);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch at result %0d: %s got %0d expected %0d",
             checked_count, what, got, want);
  endtask

  // Sender: random bursts separated by random gaps.
  int burst_left = 0;

  task automatic send_fraction_op(logic [2:0] cmd, logic [W-1:0] an, logic [W-1:0] ad,
                                  logic [W-1:0] bn, logic [W-1:0] bd);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    // start dropped at the last falling edge; raise it again on a falling edge
    @(negedge clk_i);
    command_i <= cmd; a_num_i <= an; a_den_i <= ad; b_num_i <= bn; b_den_i <= bd;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(reduce_fraction(cmd, an, ad, bn, bd));
    sent_count++;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Result checker: results are shown for one cycle with done_o.
  always @(posedge clk_i) begin
    frac_res_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        error_count++;
        $display("unexpected result with nothing pending");
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.st) report_mismatch("status", status_o, e.st);
        if (res_num_o !== e.num) report_mismatch("res_num", res_num_o, e.num);
        if (res_den_o !== e.den) report_mismatch("res_den", res_den_o, e.den);
        status_seen[e.st]++;
        checked_count++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("FAILURE");
      $finish;
    end
  end

  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

  // Values biased toward small magnitudes, extremes and all-random bits.
  function automatic logic [W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MAXP;
      1: return MINN;
      2: return W'($urandom_range(0, 1)) ? W'(-1) : W'(1);
      3, 4: return $urandom;
      5: return $urandom >> $urandom_range(0, W-1);
      default: return W'($signed($urandom_range(0, 60)) - 30);
    endcase
  endfunction

  task automatic test_directed_extremes();
    send_fraction_op(CMD_ADD, 1, 2, 1, 3);
    send_fraction_op(CMD_SUB, 1, 2, 1, 2);          // zero result is 0/1
    send_fraction_op(CMD_MUL, MINN, 1, MINN, 1);    // overflow
    send_fraction_op(CMD_DIV, 3, 4, -6, 8);
    send_fraction_op(CMD_NEG, MINN, 1, 0, 0);       // negating the minimum overflows
    send_fraction_op(CMD_NEG, MINN, -1, 0, 0);
    send_fraction_op(CMD_INC, MAXP, 1, 0, 0);
    send_fraction_op(CMD_DEC, MINN, 1, 0, 0);
    send_fraction_op(CMD_ADD, 1, 0, 1, 1);          // zero first denominator
    send_fraction_op(CMD_MUL, 1, 1, 1, 0);          // zero second denominator
    send_fraction_op(CMD_NEG, 5, 7, 3, 0);          // unary ignores the second fraction
    send_fraction_op(CMD_DIV, 1, 0, 0, 1);          // zero denominator wins
    send_fraction_op(CMD_DIV, 1, 2, 0, 5);          // division by zero
    send_fraction_op(CMD_PASS, 6, -4, 0, 0);
    send_fraction_op(CMD_PASS, MINN, MINN, 0, 0);
    send_fraction_op(CMD_ADD, MAXP, MAXP, MINN, MINN);
    send_fraction_op(CMD_MUL, MAXP, MINN, MINN, MAXP);
    send_fraction_op(CMD_DIV, '1, MINN, MINN, '1);
    send_fraction_op(CMD_SUB, MAXP, 1, MINN, 1);
    send_fraction_op(CMD_INC, -1, -1, 0, 0);
  endtask

  task automatic test_drain_pause();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic test_random_ops(int count);
    logic [2:0] cmd;
    logic [W-1:0] an, ad, bn, bd;
    repeat (count) begin
      cmd = 3'($urandom_range(0, 7));
      an = pick_value(); ad = pick_value(); bn = pick_value(); bd = pick_value();
      send_fraction_op(cmd, an, ad, bn, bd);
    end
  endtask

  task automatic test_sign_and_bits();
    // walking ones through every field bit, both polarities
    for (int i = 0; i < W; i++) begin
      send_fraction_op(3'(i % 8), W'(1) << i, ~(W'(1) << i), ~(W'(1) << i), W'(1) << i);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_drain_pause();
    test_sign_and_bits();
    test_random_ops(250);
    test_drain_pause();
    test_random_ops(250);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d commands, checked %0d results", sent_count, checked_count);
    $display("status mix ok/zero_den/div_zero/overflow: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
